FILE: sv/lrucr_pkg.sv
`default_nettype none
package lrucr_pkg;

    localparam int unsigned DefaultWays       = 16;
    localparam int unsigned DefaultTagWidth   = 16;
    localparam int unsigned DefaultStampWidth = 32;

    localparam int unsigned PageWidth  = 16;
    localparam int unsigned WayWidth   = 4;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned CfgWidth   = 5;
    localparam logic [CfgWidth-1:0] CfgReset = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_REDUCE,
        S_UPDATE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic load;
        logic reduce;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

FILE: sv/lrucr_ctrl.sv
`default_nettype none
module lrucr_ctrl #(
    parameter int unsigned LEVELS = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire lrucr_pkg::t_status i_status,
    output lrucr_pkg::t_cmd        o_cmd
);

    localparam int unsigned LvlWidth = $clog2(LEVELS + 1);

    lrucr_pkg::t_state r_state, n_state;
    logic [LvlWidth-1:0] r_lvl, n_lvl;
    logic last_level;

    assign last_level = (r_lvl == LvlWidth'(LEVELS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrucr_pkg::S_IDLE;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_lvl   = r_lvl;
        unique case (r_state)
            lrucr_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = lrucr_pkg::S_LOAD;
                end
            end
            lrucr_pkg::S_LOAD: begin
                n_state = lrucr_pkg::S_REDUCE;
                n_lvl   = '0;
            end
            lrucr_pkg::S_REDUCE: begin
                if (last_level) begin
                    n_state = lrucr_pkg::S_UPDATE;
                end else begin
                    n_lvl = r_lvl + LvlWidth'(1);
                end
            end
            lrucr_pkg::S_UPDATE: begin
                if (i_status.out_free) begin
                    n_state = lrucr_pkg::S_IDLE;
                end
            end
            default: n_state = lrucr_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            lrucr_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            lrucr_pkg::S_LOAD:   o_cmd.load   = 1'b1;
            lrucr_pkg::S_REDUCE: o_cmd.reduce = 1'b1;
            lrucr_pkg::S_UPDATE: o_cmd.update = i_status.out_free;
            default: o_ready = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/lrucr_dp.sv
`default_nettype none
module lrucr_dp #(
    parameter int unsigned WAYS        = lrucr_pkg::DefaultWays,
    parameter int unsigned TAG_WIDTH   = lrucr_pkg::DefaultTagWidth,
    parameter int unsigned STAMP_WIDTH = lrucr_pkg::DefaultStampWidth
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lrucr_pkg::t_cmd                     i_cmd,
    output lrucr_pkg::t_status                       o_status,
    input  wire logic                                i_cfg_valid,
    input  wire logic [lrucr_pkg::CfgWidth-1:0]      i_cfg_data,
    input  wire logic [lrucr_pkg::PageWidth-1:0]     i_page,
    input  wire logic                                i_first_access,
    input  wire logic                                i_last_access,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic                                     o_hit,
    output logic [lrucr_pkg::WayWidth-1:0]           o_way,
    output logic [lrucr_pkg::CountWidth-1:0]         o_hit_count,
    output logic [lrucr_pkg::CountWidth-1:0]         o_miss_count,
    output logic                                     o_run_done
);

    localparam int unsigned IdxWidth  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int unsigned TreeSize  = 1 << IdxWidth;
    localparam int unsigned KeyWidth  = STAMP_WIDTH + 1;
    localparam int unsigned CmpWidth  = 8;
    localparam int unsigned CW        = lrucr_pkg::CountWidth;

    logic [TAG_WIDTH-1:0]   r_tag   [WAYS];
    logic [WAYS-1:0]        r_valid;
    logic [STAMP_WIDTH-1:0] r_stamp [WAYS];
    logic [STAMP_WIDTH-1:0] r_counter;
    logic [CW-1:0]          r_hits, r_misses;
    logic [lrucr_pkg::CfgWidth-1:0] r_cfg;

    logic [TAG_WIDTH-1:0]   r_page;
    logic                   r_last;
    logic                   r_found;
    logic [IdxWidth-1:0]    r_hit_idx;
    logic [KeyWidth-1:0]    r_key [TreeSize];
    logic [IdxWidth-1:0]    r_idx [TreeSize];

    logic                   r_out_valid;
    logic                   r_out_hit;
    logic [lrucr_pkg::WayWidth-1:0] r_out_way;
    logic [CW-1:0]          r_out_hits, r_out_misses;
    logic                   r_out_done;

    logic [WAYS-1:0]        live;
    logic [WAYS-1:0]        match;
    logic                   n_found;
    logic [IdxWidth-1:0]    n_hit_idx;
    logic [TAG_WIDTH+lrucr_pkg::PageWidth-1:0] page_ext;
    logic [IdxWidth-1:0]    chosen;
    logic [IdxWidth+lrucr_pkg::WayWidth-1:0] chosen_ext;
    logic [STAMP_WIDTH-1:0] n_counter;
    logic [CW-1:0]          n_hits, n_misses;

    assign page_ext = {{TAG_WIDTH{1'b0}}, i_page};

    // way 0 is always in use; a setting above WAYS uses them all
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            live[w]  = (w == 0) || (CmpWidth'(w) < CmpWidth'(r_cfg));
            match[w] = live[w] && r_valid[w] && (r_tag[w] == r_page);
        end
    end

    // lowest matching way wins
    always_comb begin
        n_found   = |match;
        n_hit_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                n_hit_idx = IdxWidth'(w);
            end
        end
    end

    assign chosen     = r_found ? r_hit_idx : r_idx[0];
    assign chosen_ext = {{lrucr_pkg::WayWidth{1'b0}}, chosen};
    assign n_counter  = (r_counter == {STAMP_WIDTH{1'b1}}) ? r_counter
                                                           : r_counter + STAMP_WIDTH'(1);
    assign n_hits     = (r_found && r_hits != {CW{1'b1}}) ? r_hits + CW'(1) : r_hits;
    assign n_misses   = (!r_found && r_misses != {CW{1'b1}}) ? r_misses + CW'(1) : r_misses;

    assign o_status.out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lrucr_pkg::CfgReset;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // cache state with reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_stamp[w] <= '0;
            end
        end else if (i_cmd.accept && i_first_access) begin
            r_valid   <= '0;
            r_counter <= '0;
            r_hits    <= '0;
            r_misses  <= '0;
            for (int w = 0; w < WAYS; w++) begin
                r_stamp[w] <= '0;
            end
        end else if (i_cmd.update) begin
            r_valid[chosen] <= 1'b1;
            r_stamp[chosen] <= n_counter;
            r_counter       <= n_counter;
            r_hits          <= n_hits;
            r_misses        <= n_misses;
        end
    end

    // tags and per-transaction working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_page <= page_ext[TAG_WIDTH-1:0];
            r_last <= i_last_access;
        end
        if (i_cmd.update && !r_found) begin
            r_tag[chosen] <= r_page;
        end
        if (i_cmd.load) begin
            r_found   <= n_found;
            r_hit_idx <= n_hit_idx;
            // ways out of use sort last via the top key bit
            for (int i = 0; i < TreeSize; i++) begin
                if (i < WAYS) begin
                    r_key[i] <= {~live[i], r_stamp[i]};
                end else begin
                    r_key[i] <= '1;
                end
                r_idx[i] <= IdxWidth'(i);
            end
        end else if (i_cmd.reduce) begin
            // one tree level per cycle, left side wins ties
            for (int i = 0; i < TreeSize / 2; i++) begin
                if (r_key[2*i+1] < r_key[2*i]) begin
                    r_key[i] <= r_key[2*i+1];
                    r_idx[i] <= r_idx[2*i+1];
                end else begin
                    r_key[i] <= r_key[2*i];
                    r_idx[i] <= r_idx[2*i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // counts are held with the result, a following first access may clear the totals
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out_hit    <= r_found;
            r_out_way    <= chosen_ext[lrucr_pkg::WayWidth-1:0];
            r_out_hits   <= n_hits;
            r_out_misses <= n_misses;
            r_out_done   <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_way        = r_out_way;
    assign o_hit_count  = r_out_hits;
    assign o_miss_count = r_out_misses;
    assign o_run_done   = r_out_done;

endmodule
`default_nettype wire

FILE: sv/lru_cache_replacement.sv
// Fully associative LRU cache lookup with timestamp replacement.
// Input channel (i_valid/o_ready) carries one access: i_page, i_first_access
// (clears tags' valid bits, stamps and counts before the access) and
// i_last_access (echoed as o_run_done).
// Output channel (o_valid/i_ready) returns one result per access: hit flag,
// way used, and running saturating hit and miss counts.
// Configuration channel (i_cfg_valid/o_cfg_ready, always ready) writes the
// number of ways in use; write it only while no access is in flight.
// An accepted access passes the tag compare, then each level of the
// registered min-stamp tree in turn, then the stamp and tag update.
// One access is in flight at a time, so a new access is taken only after
// the last one has finished its update.
// The result sits in an output register; a new access is taken while it
// waits, but the following update holds until the receiver takes it.
// Reset clears valid bits, stamps, counters and sets all 16 ways in use.
`default_nettype none
module lru_cache_replacement #(
    parameter int unsigned WAYS        = lrucr_pkg::DefaultWays,
    parameter int unsigned TAG_WIDTH   = lrucr_pkg::DefaultTagWidth,
    parameter int unsigned STAMP_WIDTH = lrucr_pkg::DefaultStampWidth
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lrucr_pkg::CfgWidth-1:0]   i_cfg_data,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic [lrucr_pkg::PageWidth-1:0]  i_page,
    input  wire logic                             i_first_access,
    input  wire logic                             i_last_access,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic                                  o_hit,
    output logic [lrucr_pkg::WayWidth-1:0]        o_way,
    output logic [lrucr_pkg::CountWidth-1:0]      o_hit_count,
    output logic [lrucr_pkg::CountWidth-1:0]      o_miss_count,
    output logic                                  o_run_done
);

    localparam int unsigned Levels = (WAYS > 1) ? $clog2(WAYS) : 1;

    lrucr_pkg::t_cmd    cmd;
    lrucr_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    lrucr_ctrl #(
        .LEVELS (Levels)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    lrucr_dp #(
        .WAYS        (WAYS),
        .TAG_WIDTH   (TAG_WIDTH),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_page         (i_page),
        .i_first_access (i_first_access),
        .i_last_access  (i_last_access),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_way          (o_way),
        .o_hit_count    (o_hit_count),
        .o_miss_count   (o_miss_count),
        .o_run_done     (o_run_done)
    );

endmodule
`default_nettype wire
